FILE: sv/sre_pkg.sv
// ============================================================================
// sre_pkg
// Shared constants, codes and types of the stack rotate engine.
// ============================================================================
package sre_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int FUNC_W      = 3;
    localparam int ENTRY_W     = 11;

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [DATA_W-1:0] t_data;

    // Value returned by a pop that finds the stack empty.
    localparam t_data EMPTY_VALUE = '1;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_SWAP = 3'd2,
        OP_ROT  = 3'd3,
        OP_RROT = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SWAP_RD,
        ST_SWAP_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_data              popped_value;
        logic               empty_flag;
        logic               overflow_flag;
        logic [ENTRY_W-1:0] entry_count;
    } t_result;

endpackage

FILE: sv/sre_if.sv
// ============================================================================
// sre_if
// Valid/ready channels of the stack rotate engine: command in, result out.
// ============================================================================
interface sre_cmd_if import sre_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    t_data             push_value;

    modport source (output valid, output func, output push_value, input ready);
    modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface sre_res_if import sre_pkg::*; ();
    logic               valid;
    logic               ready;
    t_data              popped_value;
    logic               empty_flag;
    logic               overflow_flag;
    logic [ENTRY_W-1:0] entry_count;

    modport source (output valid, output popped_value, output empty_flag,
                    output overflow_flag, output entry_count, input ready);
    modport sink   (input valid, input popped_value, input empty_flag,
                    input overflow_flag, input entry_count, output ready);
endinterface

FILE: sv/stack_rotate_engine.sv
// ============================================================================
// stack_rotate_engine
// Bounded stack of signed 32-bit words held in a ring buffer in one RAM.
// ============================================================================
// Usage:
// Commands arrive on i_cmd (func, push_value) and every command yields
// exactly one item on o_res (popped_value, empty_flag, overflow_flag,
// entry_count). Both channels move an item when valid and ready are high.
// The entries live in a single RAM with one write and one registered read
// port; top pointer and count are registers. The bottom entry sits at
// slot top - count + 1, modulo the depth.
// Push, and any command that leaves the stack untouched (empty pop, full
// push, swap or rotate on fewer than two entries, unused codes), finishes
// in the accept cycle: one item per cycle without a stall, result registered.
// Pop needs one RAM read, rotate and reverse rotate one read before their
// write; they finish in ST_FETCH. Swap reads two entries and writes two
// through the single ports, via ST_FETCH, ST_SWAP_RD and ST_SWAP_WR.
// After reset the stack is empty; the RAM is not cleared, because only
// held entries are ever read. When the receiver stalls, one result waits
// in the output register while the next command is still worked on; a
// second finished result parks inside and i_cmd.ready stays low until
// the output register frees up.
// ============================================================================
module stack_rotate_engine import sre_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sre_cmd_if.sink       i_cmd,
    sre_res_if.source     o_res
);

    // Ring pointer helpers; the depth need not be a power of two.
    function automatic t_idx idx_inc(input t_idx a);
        return (a == t_idx'(STACK_DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic t_idx idx_dec(input t_idx a);
        return (a == '0) ? t_idx'(STACK_DEPTH - 1) : a - 1'b1;
    endfunction

    // Slot a - n modulo the depth, for 0 <= n <= depth.
    function automatic t_idx slot_sub(input t_idx a, input t_cnt n);
        logic [CNT_W:0] w;
        w = (CNT_W+1)'(a) + (CNT_W+1)'(STACK_DEPTH) - (CNT_W+1)'(n);
        if (w >= (CNT_W+1)'(STACK_DEPTH)) begin
            w = w - (CNT_W+1)'(STACK_DEPTH);
        end
        return w[IDX_W-1:0];
    endfunction

    t_state  r_state, n_state;
    t_idx    r_top, n_top;
    t_cnt    r_count, n_count;
    t_op     r_op, n_op;
    t_data   r_hold, n_hold;
    t_result r_res, n_res;
    t_result r_out, n_out;
    logic    r_out_valid, n_out_valid;

    logic    mem_we;
    t_idx    mem_waddr;
    t_data   mem_wdata;
    t_idx    mem_raddr;
    t_data   mem_rdata;

    logic    finish;
    t_data   res_popped;
    logic    res_empty;
    logic    res_over;

    sre_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_cmd.ready         = (r_state == ST_IDLE);
    assign o_res.valid         = r_out_valid;
    assign o_res.popped_value  = r_out.popped_value;
    assign o_res.empty_flag    = r_out.empty_flag;
    assign o_res.overflow_flag = r_out.overflow_flag;
    assign o_res.entry_count   = r_out.entry_count;

    // Sequencer: issue reads, do the write-back, and finish the command.
    always_comb begin
        n_state    = r_state;
        n_top      = r_top;
        n_count    = r_count;
        n_op       = r_op;
        n_hold     = r_hold;
        mem_we     = 1'b0;
        mem_waddr  = r_top;
        mem_wdata  = mem_rdata;
        mem_raddr  = r_top;
        finish     = 1'b0;
        res_popped = '0;
        res_empty  = 1'b0;
        res_over   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_op = t_op'(i_cmd.func);
                    case (t_op'(i_cmd.func)) inside
                        OP_PUSH: begin
                            finish = 1'b1;
                            if (r_count == t_cnt'(STACK_DEPTH)) begin
                                res_over = 1'b1;
                            end else begin
                                n_top     = (r_count != '0) ? idx_inc(r_top) : r_top;
                                mem_we    = 1'b1;
                                mem_waddr = n_top;
                                mem_wdata = i_cmd.push_value;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                res_popped = EMPTY_VALUE;
                                res_empty  = 1'b1;
                                finish     = 1'b1;
                            end else begin
                                n_state = ST_FETCH;
                            end
                        end
                        OP_SWAP, OP_ROT: begin
                            if (r_count >= t_cnt'(2)) begin
                                n_state = ST_FETCH;
                            end else begin
                                finish = 1'b1;
                            end
                        end
                        OP_RROT: begin
                            if (r_count >= t_cnt'(2)) begin
                                mem_raddr = slot_sub(r_top, r_count - 1'b1);
                                n_state   = ST_FETCH;
                            end else begin
                                finish = 1'b1;
                            end
                        end
                        default: begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                case (r_op)
                    OP_POP: begin
                        res_popped = mem_rdata;
                        n_count    = r_count - 1'b1;
                        if (r_count != t_cnt'(1)) begin
                            n_top = idx_dec(r_top);
                        end
                        finish = 1'b1;
                    end
                    OP_SWAP: begin
                        n_hold    = mem_rdata;
                        mem_raddr = idx_dec(r_top);
                        n_state   = ST_SWAP_RD;
                    end
                    OP_ROT: begin
                        mem_we    = 1'b1;
                        mem_waddr = slot_sub(r_top, r_count);
                        n_top     = idx_dec(r_top);
                        finish    = 1'b1;
                    end
                    OP_RROT: begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_inc(r_top);
                        n_top     = idx_inc(r_top);
                        finish    = 1'b1;
                    end
                    default: begin
                        finish = 1'b1;
                    end
                endcase
            end
            ST_SWAP_RD: begin
                // The lower entry moves up to the top slot.
                mem_we  = 1'b1;
                n_state = ST_SWAP_WR;
            end
            ST_SWAP_WR: begin
                mem_we    = 1'b1;
                mem_waddr = idx_dec(r_top);
                mem_wdata = r_hold;
                finish    = 1'b1;
            end
            ST_DONE: begin
                finish = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (r_state == ST_DONE) begin
            n_res = r_res;
        end else begin
            n_res.popped_value  = res_popped;
            n_res.empty_flag    = res_empty;
            n_res.overflow_flag = res_over;
            n_res.entry_count   = ENTRY_W'(n_count);
        end

        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;
        if (finish) begin
            if (!r_out_valid || o_res.ready) begin
                n_out       = n_res;
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end else begin
                n_state = ST_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_top       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_hold <= n_hold;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // The count never exceeds the ring size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(STACK_DEPTH))
        else $error("entry count beyond stack depth");

    // One command moves the count by at most one entry.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count) ||
                            r_count == $past(r_count) + 1'b1 ||
                            r_count == $past(r_count) - 1'b1))
        else $error("entry count jumped");

    // The swap write-back phases leave pointer and count alone.
    a_swap_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWAP_RD) |=> ($stable(r_count) && $stable(r_top)))
        else $error("swap changed pointer or count");

    // An empty pop reports an empty stack.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.empty_flag) |-> (o_res.entry_count == '0))
        else $error("empty flag with entries held");

    // A dropped push reports a full stack.
    a_over_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.overflow_flag) |->
            (o_res.entry_count == ENTRY_W'(STACK_DEPTH)))
        else $error("overflow flag without full stack");

endmodule

FILE: sv/sre_ram.sv
// ============================================================================
// sre_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ============================================================================
module sre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: tb/stack_rotate_engine_tb.sv
// ============================================================================
// stack_rotate_engine_tb
// Self-checking bench for the ring-buffer stack with swap and rotate.
// Commands go in through the valid/ready command channel. A shadow stack
// works out the expected result of every accepted command, and each result
// item taken off the result channel is compared with the oldest one pending.
// The run starts with a short directed sequence, continues with random
// traffic on a shallow stack, and ends by draining the stack to empty with
// no idling on either side.
// ============================================================================
module stack_rotate_engine_tb import sre_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 340;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int FUNC_MAX      = (1 << FUNC_W) - 1;
    localparam int FIRST_UNUSED  = int'(OP_RROT) + 1;

    // Shadow of the stack plus the queue of results it has predicted.
    class stack_scoreboard;
        t_data   ring [STACK_DEPTH];
        t_idx    top_slot   = '0;
        t_cnt    depth_held = '0;
        t_result expected_results [$];
        int      errors     = 0;
        int      n_commands = 0;
        int      n_checked  = 0;
        int      n_overflow = 0;
        int      n_empty    = 0;
        int      n_moves    = 0;
        int      peak_depth = 0;

        function int pending();
            return expected_results.size();
        endfunction

        task report_mismatch(input string what, input logic [63:0] got,
                             input logic [63:0] want);
            errors++;
            $display("ERROR result %0d: %s got 0x%0h, expected 0x%0h",
                     n_checked, what, got, want);
        endtask

        // Applies one accepted command to the shadow and queues its result.
        function void note_command(input logic [FUNC_W-1:0] func, input t_data value);
            t_result r;
            t_idx    slot;
            t_data   moved;
            r = '0;
            n_commands++;
            case (func)
                OP_PUSH: begin
                    if (depth_held >= STACK_DEPTH) begin
                        r.overflow_flag = 1'b1;
                        n_overflow++;
                    end else begin
                        if (depth_held != 0) top_slot = top_slot + 1'b1;
                        ring[top_slot] = value;
                        depth_held++;
                    end
                end
                OP_POP: begin
                    if (depth_held == 0) begin
                        r.popped_value = EMPTY_VALUE;
                        r.empty_flag   = 1'b1;
                        n_empty++;
                    end else begin
                        r.popped_value = ring[top_slot];
                        depth_held--;
                        if (depth_held != 0) top_slot = top_slot - 1'b1;
                    end
                end
                OP_SWAP: begin
                    if (depth_held >= 2) begin
                        slot           = top_slot - 1'b1;
                        moved          = ring[top_slot];
                        ring[top_slot] = ring[slot];
                        ring[slot]     = moved;
                        n_moves++;
                    end
                end
                OP_ROT: begin
                    // The top entry lands just below the bottom one; on a
                    // full ring that is its own slot and only the pointer moves.
                    if (depth_held >= 2) begin
                        slot       = top_slot - t_idx'(depth_held);
                        ring[slot] = ring[top_slot];
                        top_slot   = top_slot - 1'b1;
                        n_moves++;
                    end
                end
                OP_RROT: begin
                    if (depth_held >= 2) begin
                        slot           = top_slot - t_idx'(depth_held - 1'b1);
                        moved          = ring[slot];
                        top_slot       = top_slot + 1'b1;
                        ring[top_slot] = moved;
                        n_moves++;
                    end
                end
                default: ;
            endcase
            r.entry_count = ENTRY_W'(depth_held);
            if (int'(depth_held) > peak_depth) peak_depth = int'(depth_held);
            expected_results.push_back(r);
        endfunction

        task check_result(input t_data popped, input logic empty, input logic over,
                          input logic [ENTRY_W-1:0] count);
            t_result want;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result item", {popped, empty, over, count}, '0);
            end else begin
                want = expected_results.pop_front();
                if (popped !== want.popped_value)
                    report_mismatch("popped_value", popped, want.popped_value);
                if (empty !== want.empty_flag)
                    report_mismatch("empty_flag", empty, want.empty_flag);
                if (over !== want.overflow_flag)
                    report_mismatch("overflow_flag", over, want.overflow_flag);
                if (count !== want.entry_count)
                    report_mismatch("entry_count", count, want.entry_count);
            end
            n_checked++;
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    bit   idle_on = 1'b0;
    int   stall_left  = 0;
    int   cycle_count = 0;
    int   depth_guess = 0;

    stack_scoreboard sb = new();

    sre_cmd_if cmd_ch ();
    sre_res_if res_ch ();

    stack_rotate_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycle_count, sb.pending());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: ready drops in random bursts while idling is on.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left   <= $urandom_range(0, 3);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Both channels are sampled on the edge, before any update of this step lands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready)
                sb.note_command(cmd_ch.func, cmd_ch.push_value);
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.popped_value, res_ch.empty_flag,
                                res_ch.overflow_flag, res_ch.entry_count);
        end
    end

    // Presents one command and holds it until accepted. The bench keeps its own
    // rough depth so the drain phase knows when to stop.
    task automatic send_item(input logic [FUNC_W-1:0] f, input t_data v);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.func       <= f;
        cmd_ch.push_value <= v;
        do @(posedge i_clk); while (!cmd_ch.ready);
        if (f == OP_PUSH && depth_guess < STACK_DEPTH) depth_guess++;
        if (f == OP_POP && depth_guess > 0) depth_guess--;
    endtask

    function automatic t_data pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return EMPTY_VALUE;
            default: return t_data'($urandom);
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] pick_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) return OP_PUSH;
        if (roll < 60) return OP_POP;
        if (roll < 72) return OP_SWAP;
        if (roll < 84) return OP_ROT;
        if (roll < 96) return OP_RROT;
        return FUNC_W'($urandom_range(FIRST_UNUSED, FUNC_MAX));
    endfunction

    initial begin
        cmd_ch.valid      = 1'b0;
        cmd_ch.func       = OP_PUSH;
        cmd_ch.push_value = '0;
        res_ch.ready      = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: everything on an empty and a one-entry stack, the value
        // extremes, and every operation on a few entries.
        send_item(OP_POP,  '0);
        send_item(OP_SWAP, '0);
        send_item(OP_ROT,  '0);
        send_item(OP_RROT, '0);
        send_item(FUNC_W'(FIRST_UNUSED), 32'sh1234_5678);
        send_item(FUNC_W'(FUNC_MAX), EMPTY_VALUE);
        send_item(OP_PUSH, 32'sh7FFF_FFFF);
        send_item(OP_SWAP, '0);
        send_item(OP_ROT,  '0);
        send_item(OP_RROT, '0);
        send_item(OP_PUSH, 32'sh8000_0000);
        send_item(OP_SWAP, '0);
        send_item(OP_PUSH, '0);
        send_item(OP_PUSH, EMPTY_VALUE);
        send_item(OP_ROT,  '0);
        send_item(OP_RROT, '0);
        send_item(OP_RROT, '0);
        send_item(OP_SWAP, '0);
        send_item(FUNC_W'(FIRST_UNUSED + 1), '0);
        send_item(OP_POP,  '0);
        send_item(OP_POP,  '0);
        send_item(OP_POP,  '0);
        send_item(OP_POP,  '0);
        send_item(OP_POP,  '0);

        // Random traffic on a shallow stack; idling is switched per window so
        // some stretches run back to back.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
            send_item(pick_op(), pick_value());
        end

        // Last part: drain to empty with no idling on either side.
        idle_on = 1'b0;
        while (depth_guess > 0) begin
            if ($urandom_range(0, 9) == 0) send_item(OP_RROT, '0);
            else                           send_item(OP_POP, '0);
        end
        repeat (2) send_item(OP_POP, '0);
        cmd_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d commands and checked %0d results, peak depth %0d of %0d.",
                 sb.n_commands, sb.n_checked, sb.peak_depth, STACK_DEPTH);
        $display("Saw %0d dropped pushes, %0d empty pops, %0d swaps and rotates.",
                 sb.n_overflow, sb.n_empty, sb.n_moves);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/sre_pkg.sv
sv/sre_if.sv
sv/sre_ram.sv
sv/stack_rotate_engine.sv
tb/stack_rotate_engine_tb.sv
